@@ hw/rtl/dtt_pkg.sv @@
// ----------------------------------------------------------------------------
// dtt_pkg
// Shared types and constants of the delayed event timer table.
// ----------------------------------------------------------------------------
`default_nettype none

package dtt_pkg;

  // Table size and derived index widths.
  localparam int SLOTS = 16;
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);

  // Request action codes.
  typedef enum logic [1:0] {
    ACT_START  = 2'd0,
    ACT_TICK   = 2'd1,
    ACT_CANCEL = 2'd2,
    ACT_NONE   = 2'd3
  } action_e;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_FIRED    = 2'd0,
    KIND_ACCEPTED = 2'd1,
    KIND_REJECTED = 2'd2,
    KIND_CANCELED = 2'd3
  } kind_e;

  // Operations of the shared compare unit.
  typedef enum logic {
    ALU_SUB = 1'b0,
    ALU_EQ  = 1'b1
  } alu_op_e;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_SCAN = 2'd1,
    ST_FIN  = 2'd2
  } seq_state_e;

  // Input request payload.
  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] owner_id;
    logic [15:0] event_tag;
    logic [23:0] delay;
    logic [15:0] elapsed;
  } req_t;

  // Result payload.
  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] fired_owner;
    logic [15:0] fired_tag;
    logic [6:0]  cancelled_count;
    logic        last_result;
  } rsp_t;

  // One stored slot entry.
  typedef struct packed {
    logic [23:0] remaining;
    logic [15:0] owner;
    logic [15:0] tag;
  } slot_t;

  // Control from the sequencer to the slot store.
  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    slot_t            wr_data;
    logic             rd_en;
    logic [IDX_W-1:0] rd_idx;
    logic             set_en;
    logic             clr_en;
    logic [IDX_W-1:0] vld_idx;
  } store_ctl_t;

  // Result of the shared compare unit.
  typedef struct packed {
    logic        due;
    logic        match;
    logic [23:0] diff;
  } alu_res_t;

endpackage

`default_nettype wire

@@ hw/rtl/dtt_alu.sv @@
// ----------------------------------------------------------------------------
// dtt_alu
// Shared subtract and compare unit, used once per visited slot.
// ----------------------------------------------------------------------------
`default_nettype none

module dtt_alu import dtt_pkg::*; (
  input  alu_op_e     op_i,
  input  logic [23:0] remaining_i,
  input  logic [15:0] elapsed_i,
  input  logic [15:0] slot_owner_i,
  input  logic [15:0] req_owner_i,
  output alu_res_t    res_o
);

  logic [24:0] diff;

  // One wide subtract yields both the new remaining time and the due flag.
  assign diff = {1'b0, remaining_i} - {9'd0, elapsed_i};

  always_comb begin
    res_o = '0;
    unique case (op_i)
      ALU_SUB: begin
        res_o.diff = diff[23:0];
        res_o.due  = diff[24] | (diff[23:0] == 24'd0);
      end
      ALU_EQ: begin
        res_o.match = (slot_owner_i == req_owner_i);
      end
      default: begin
        res_o = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ hw/rtl/dtt_store.sv @@
// ----------------------------------------------------------------------------
// dtt_store
// Slot memory with registered read, plus one valid flop per slot.
// ----------------------------------------------------------------------------
`default_nettype none

module dtt_store import dtt_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  store_ctl_t       ctl_i,
  output slot_t            rd_data_o,
  output logic [SLOTS-1:0] valid_o
);

  slot_t            mem_q [SLOTS];
  slot_t            rd_data_q;
  logic [SLOTS-1:0] valid_q;

  // Memory write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[ctl_i.wr_idx] <= ctl_i.wr_data;
    end
    if (ctl_i.rd_en) begin
      rd_data_q <= mem_q[ctl_i.rd_idx];
    end
  end

  // Valid bits are cleared at reset; set on a start, cleared on fire or cancel.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (ctl_i.set_en) begin
      valid_q[ctl_i.vld_idx] <= 1'b1;
    end else if (ctl_i.clr_en) begin
      valid_q[ctl_i.vld_idx] <= 1'b0;
    end
  end

  assign rd_data_o = rd_data_q;
  assign valid_o   = valid_q;

endmodule

`default_nettype wire

@@ hw/rtl/dtt_seq.sv @@
// ----------------------------------------------------------------------------
// dtt_seq
// Sequencer walking one slot per cycle unless a fire stalls; owns the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module dtt_seq import dtt_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  req_t             in_data_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  output rsp_t             out_data_o,
  input  logic             out_stall_i,
  output store_ctl_t       ctl_o,
  input  slot_t            rd_data_i,
  input  logic [SLOTS-1:0] valid_i,
  output alu_op_e          alu_op_o,
  input  alu_res_t         alu_res_i,
  output logic [15:0]      req_owner_o,
  output logic [15:0]      elapsed_o
);

  seq_state_e       state_q, state_d;
  req_t             req_q, req_d;
  logic [CNT_W-1:0] rd_idx_q, rd_idx_d;
  logic             p_vld_q, p_vld_d;
  logic [IDX_W-1:0] p_idx_q, p_idx_d;
  logic             found_q, found_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             pend_q, pend_d;
  logic [15:0]      pend_owner_q, pend_owner_d;
  logic [15:0]      pend_tag_q, pend_tag_d;
  logic             out_valid_q, out_valid_d;
  rsp_t             out_q, out_d;

  logic in_accept;
  logic out_free;
  logic cur_v;
  logic hold;
  logic adv;
  logic last_slot;
  logic emit_en;
  rsp_t emit_data;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign cur_v       = valid_i[p_idx_q];
  assign last_slot   = p_vld_q && (p_idx_q == IDX_W'(SLOTS - 1));
  assign req_owner_o = req_q.owner_id;
  assign elapsed_o   = req_q.elapsed;
  assign alu_op_o    = (req_q.action == ACT_CANCEL) ? ALU_EQ : ALU_SUB;

  // A fire while an earlier fire is still pending must wait for the result slot.
  assign hold = (state_q == ST_SCAN) && p_vld_q && (req_q.action == ACT_TICK) &&
                cur_v && alu_res_i.due && pend_q && !out_free;
  assign adv  = !hold;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept && (in_data_i.action != ACT_NONE)) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (last_slot && adv) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free || ((req_q.action == ACT_TICK) && !pend_q)) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Datapath control and result generation.
  always_comb begin
    req_d        = req_q;
    rd_idx_d     = rd_idx_q;
    p_vld_d      = p_vld_q;
    p_idx_d      = p_idx_q;
    found_d      = found_q;
    cnt_d        = cnt_q;
    pend_d       = pend_q;
    pend_owner_d = pend_owner_q;
    pend_tag_d   = pend_tag_q;
    ctl_o        = '0;
    emit_en      = 1'b0;
    emit_data    = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          req_d    = in_data_i;
          rd_idx_d = '0;
          p_vld_d  = 1'b0;
          found_d  = 1'b0;
          cnt_d    = '0;
          pend_d   = 1'b0;
        end
      end
      ST_SCAN: begin
        // Issue the read of the next slot while the previous one is processed.
        if (adv) begin
          ctl_o.rd_en  = (rd_idx_q < CNT_W'(SLOTS));
          ctl_o.rd_idx = rd_idx_q[IDX_W-1:0];
          p_vld_d      = (rd_idx_q < CNT_W'(SLOTS));
          p_idx_d      = rd_idx_q[IDX_W-1:0];
          if (rd_idx_q < CNT_W'(SLOTS)) begin
            rd_idx_d = rd_idx_q + CNT_W'(1);
          end
        end
        ctl_o.wr_idx  = p_idx_q;
        ctl_o.vld_idx = p_idx_q;
        if (p_vld_q && adv) begin
          unique case (req_q.action)
            ACT_START: begin
              if (!cur_v && !found_q) begin
                ctl_o.wr_en             = 1'b1;
                ctl_o.wr_data.remaining = req_q.delay;
                ctl_o.wr_data.owner     = req_q.owner_id;
                ctl_o.wr_data.tag       = req_q.event_tag;
                ctl_o.set_en            = 1'b1;
                found_d                 = 1'b1;
              end
            end
            ACT_TICK: begin
              if (cur_v && alu_res_i.due) begin
                // Release the previous fire; this one waits until we know
                // whether it is the last.
                ctl_o.clr_en = 1'b1;
                if (pend_q) begin
                  emit_en               = 1'b1;
                  emit_data.kind        = KIND_FIRED;
                  emit_data.fired_owner = pend_owner_q;
                  emit_data.fired_tag   = pend_tag_q;
                end
                pend_d       = 1'b1;
                pend_owner_d = rd_data_i.owner;
                pend_tag_d   = rd_data_i.tag;
              end else if (cur_v) begin
                ctl_o.wr_en             = 1'b1;
                ctl_o.wr_data           = rd_data_i;
                ctl_o.wr_data.remaining = alu_res_i.diff;
              end
            end
            ACT_CANCEL: begin
              if (cur_v && alu_res_i.match) begin
                ctl_o.clr_en = 1'b1;
                cnt_d        = cnt_q + CNT_W'(1);
              end
            end
            default: begin
              found_d = found_q;
            end
          endcase
        end
        if (last_slot && adv) begin
          p_vld_d = 1'b0;
        end
      end
      ST_FIN: begin
        // Final result of the request, marked as last.
        if (out_free) begin
          emit_data.last_result = 1'b1;
          unique case (req_q.action)
            ACT_START: begin
              emit_en        = 1'b1;
              emit_data.kind = found_q ? KIND_ACCEPTED : KIND_REJECTED;
            end
            ACT_TICK: begin
              emit_en               = pend_q;
              emit_data.kind        = KIND_FIRED;
              emit_data.fired_owner = pend_owner_q;
              emit_data.fired_tag   = pend_tag_q;
            end
            ACT_CANCEL: begin
              emit_en                   = 1'b1;
              emit_data.kind            = KIND_CANCELED;
              emit_data.cancelled_count = 7'(cnt_q);
            end
            default: begin
              emit_en = 1'b0;
            end
          endcase
        end
      end
      default: begin
        p_vld_d = 1'b0;
      end
    endcase
  end

  // Output register: loaded on emit, otherwise drained when taken.
  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (emit_en) begin
      out_d       = emit_data;
      out_valid_d = 1'b1;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      p_vld_q     <= 1'b0;
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
      found_q     <= 1'b0;
      cnt_q       <= '0;
      rd_idx_q    <= '0;
    end else begin
      state_q     <= state_d;
      p_vld_q     <= p_vld_d;
      out_valid_q <= out_valid_d;
      pend_q      <= pend_d;
      found_q     <= found_d;
      cnt_q       <= cnt_d;
      rd_idx_q    <= rd_idx_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    req_q        <= req_d;
    p_idx_q      <= p_idx_d;
    pend_owner_q <= pend_owner_d;
    pend_tag_q   <= pend_tag_d;
    out_q        <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

@@ hw/rtl/delayed_event_timer_table_unit.sv @@
// The final result of a request follows the slot walk and the finish state, held back
// while the result side stalls; fires of a tick leave earlier. No new request is taken
// until the block is idle again. The walk reads one slot per cycle through the single
// memory read port, unless a fire waits for the result register. An unused action code
// leaves the block idle. Reset: asynchronous, active low; all slots free at once, no sweep.
// ----------------------------------------------------------------------------
// delayed_event_timer_table_unit
// Table of pending delayed events with start, tick and cancel requests.
// ----------------------------------------------------------------------------
`default_nettype none

module delayed_event_timer_table_unit import dtt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  req_t in_data_i,
  output logic in_stall_o,
  output logic out_valid_o,
  output rsp_t out_data_o,
  input  logic out_stall_i
);

  store_ctl_t       ctl;
  slot_t            rd_data;
  logic [SLOTS-1:0] slot_valid;
  alu_op_e          alu_op;
  alu_res_t         alu_res;
  logic [15:0]      req_owner;
  logic [15:0]      elapsed;

  // Slot walk sequencer.
  dtt_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_stall_i (out_stall_i),
    .ctl_o       (ctl),
    .rd_data_i   (rd_data),
    .valid_i     (slot_valid),
    .alu_op_o    (alu_op),
    .alu_res_i   (alu_res),
    .req_owner_o (req_owner),
    .elapsed_o   (elapsed)
  );

  // Slot storage.
  dtt_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ctl),
    .rd_data_o (rd_data),
    .valid_o   (slot_valid)
  );

  // Shared subtract and compare unit.
  dtt_alu u_alu (
    .op_i         (alu_op),
    .remaining_i  (rd_data.remaining),
    .elapsed_i    (elapsed),
    .slot_owner_i (rd_data.owner),
    .req_owner_i  (req_owner),
    .res_o        (alu_res)
  );

  // A real request keeps the block busy in the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (in_data_i.action != ACT_NONE)) |=> in_stall_o)
    else $error("request accepted but block not busy");

  // Only fired events can be followed by more results of the same request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.kind != KIND_FIRED)) |-> out_data_o.last_result)
    else $error("non-fire result not marked last");

  // A count appears only on cancel results.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.kind != KIND_CANCELED)) |->
      (out_data_o.cancelled_count == 7'd0))
    else $error("count on a non-cancel result");

  // Slot writes, sets and clears only happen while a request is being worked on.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl.wr_en || ctl.set_en || ctl.clr_en) |-> in_stall_o)
    else $error("slot store changed while idle");

endmodule

`default_nettype wire
